// ----- rtl/msi_directory_controller_core_assert.svh -----
`ifndef MSI_DIRECTORY_CONTROLLER_CORE_ASSERT_SVH
`define MSI_DIRECTORY_CONTROLLER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define MSIDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("msidc assertion failed");

// Next-cycle implication, checked outside reset.
`define MSIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("msidc assertion failed");

`endif

// ----- rtl/msidc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package msidc_pkg;

    localparam int CACHES_DEF = 8;

    localparam logic [1:0] ST_I  = 2'd0;
    localparam logic [1:0] ST_S  = 2'd1;
    localparam logic [1:0] ST_M  = 2'd2;
    localparam logic [1:0] ST_SD = 2'd3;

    localparam logic [3:0] K_GETS = 4'd0;
    localparam logic [3:0] K_GETM = 4'd1;
    localparam logic [3:0] K_PUTS = 4'd2;
    localparam logic [3:0] K_PUTM = 4'd3;
    localparam logic [3:0] K_DATA = 4'd4;

    localparam logic [2:0] MT_DATA    = 3'd0;
    localparam logic [2:0] MT_PUTACK  = 3'd1;
    localparam logic [2:0] MT_FWDGETS = 3'd2;
    localparam logic [2:0] MT_FWDGETM = 3'd3;
    localparam logic [2:0] MT_INV     = 3'd4;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_STALL     = 2'd1;
    localparam logic [1:0] STAT_UNHANDLED = 2'd2;
    localparam logic [1:0] STAT_BADSTATE  = 2'd3;

    typedef struct packed {
        logic accept;
        logic emit_inv;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic start_inv;
        logic inv_final;
    } dp_stat_t;

endpackage

`default_nettype wire

// ----- rtl/msidc_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msidc_ctrl
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire msidc_pkg::dp_stat_t  stat,
    output logic                      in_ready,
    output msidc_pkg::ctrl_cmd_t      cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.emit_inv = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = stat.out_free;
                cmd.accept = in_valid && stat.out_free;
                if (cmd.accept && stat.start_inv)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_inv = stat.out_free;
                if (stat.out_free && stat.inv_final)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/msidc_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none

module msidc_dp
#(
    parameter int CACHES = msidc_pkg::CACHES_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [7:0]           in_data,
    input  wire logic [3:0]           in_user,
    input  wire logic                 out_ready,
    input  wire msidc_pkg::ctrl_cmd_t cmd,
    output msidc_pkg::dp_stat_t       stat,
    output logic                      out_valid,
    output logic [15:0]               out_data,
    output logic [2:0]                out_user,
    output logic                      out_last
);

    localparam logic [7:0] CacheMask = (CACHES >= 8) ? 8'hFF : 8'((1 << CACHES) - 1);

    logic [1:0]  line_reg,   line_next;
    logic [2:0]  owner_reg,  owner_next;
    logic        ownv_reg,   ownv_next;
    logic [7:0]  sharer_reg, sharer_next;
    logic [7:0]  pend_reg,   pend_next;
    logic [2:0]  req_reg;
    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_data_reg;
    logic [2:0]  out_user_reg;
    logic        out_last_reg;

    logic [2:0]  src;
    logic [3:0]  kind;
    logic [7:0]  sbit;
    logic [7:0]  shm;
    logic [7:0]  others;
    logic [3:0]  num;
    logic [2:0]  ack_sat;
    logic [7:0]  inv_mask;
    logic        r_valid;
    logic [2:0]  r_type;
    logic [2:0]  r_dest;
    logic        r_onb;
    logic [2:0]  r_req;
    logic [2:0]  r_ack;
    logic        r_ord;
    logic [1:0]  r_status;
    logic [2:0]  inv_idx;
    logic [7:0]  inv_bit;
    logic [7:0]  pend_rest;

    assign src     = in_data[2:0];
    assign kind    = in_user;
    assign sbit    = 8'b1 << src;
    assign shm     = sharer_reg & CacheMask;
    assign others  = shm & ~sbit;
    assign num     = 4'($countones(others));
    assign ack_sat = (num > 4'd7) ? 3'd7 : num[2:0];

    always_comb
    begin
        line_next   = line_reg;
        owner_next  = owner_reg;
        ownv_next   = ownv_reg;
        sharer_next = sharer_reg;
        inv_mask    = 8'd0;
        r_valid     = 1'b1;
        r_type      = msidc_pkg::MT_PUTACK;
        r_dest      = src;
        r_onb       = 1'b0;
        r_req       = 3'd0;
        r_ack       = 3'd0;
        r_ord       = 1'b1;
        r_status    = msidc_pkg::STAT_OK;
        if (!CacheMask[src])
        begin
            r_valid  = 1'b0;
            r_status = msidc_pkg::STAT_UNHANDLED;
        end
        else
        begin
            sharer_next = shm;
            unique case (line_reg)
                msidc_pkg::ST_I:
                begin
                    if (num != 4'd0)
                    begin
                        r_valid  = 1'b0;
                        r_status = msidc_pkg::STAT_BADSTATE;
                    end
                    else
                    begin
                        case (kind)
                            msidc_pkg::K_GETS:
                            begin
                                r_type      = msidc_pkg::MT_DATA;
                                r_ord       = 1'b0;
                                sharer_next = shm | sbit;
                                line_next   = msidc_pkg::ST_S;
                            end
                            msidc_pkg::K_GETM:
                            begin
                                r_type     = msidc_pkg::MT_DATA;
                                r_ord      = 1'b0;
                                owner_next = src;
                                ownv_next  = 1'b1;
                                line_next  = msidc_pkg::ST_M;
                            end
                            msidc_pkg::K_PUTS, msidc_pkg::K_PUTM:
                            begin
                                r_type = msidc_pkg::MT_PUTACK;
                            end
                            default:
                            begin
                                r_valid  = 1'b0;
                                r_status = msidc_pkg::STAT_UNHANDLED;
                            end
                        endcase
                    end
                end
                msidc_pkg::ST_S:
                begin
                    case (kind)
                        msidc_pkg::K_GETS:
                        begin
                            r_type      = msidc_pkg::MT_DATA;
                            r_ord       = 1'b0;
                            sharer_next = shm | sbit;
                        end
                        msidc_pkg::K_GETM:
                        begin
                            r_type      = msidc_pkg::MT_DATA;
                            r_ord       = 1'b0;
                            r_ack       = ack_sat;
                            inv_mask    = others;
                            sharer_next = 8'd0;
                            owner_next  = src;
                            ownv_next   = 1'b1;
                            line_next   = msidc_pkg::ST_M;
                        end
                        msidc_pkg::K_PUTS:
                        begin
                            sharer_next = shm & ~sbit;
                            if ((shm & ~sbit) == 8'd0)
                            begin
                                line_next = msidc_pkg::ST_I;
                            end
                        end
                        msidc_pkg::K_PUTM:
                        begin
                            sharer_next = shm & ~sbit;
                        end
                        default:
                        begin
                            r_valid  = 1'b0;
                            r_status = msidc_pkg::STAT_UNHANDLED;
                        end
                    endcase
                end
                msidc_pkg::ST_M:
                begin
                    if (!ownv_reg)
                    begin
                        r_valid  = 1'b0;
                        r_status = msidc_pkg::STAT_BADSTATE;
                    end
                    else
                    begin
                        case (kind)
                            msidc_pkg::K_GETS:
                            begin
                                r_type      = msidc_pkg::MT_FWDGETS;
                                r_dest      = owner_reg;
                                r_onb       = 1'b1;
                                r_req       = src;
                                sharer_next = (shm | sbit | (8'b1 << owner_reg)) & CacheMask;
                                ownv_next   = 1'b0;
                                owner_next  = 3'd0;
                                line_next   = msidc_pkg::ST_SD;
                            end
                            msidc_pkg::K_GETM:
                            begin
                                r_type     = msidc_pkg::MT_FWDGETM;
                                r_dest     = owner_reg;
                                r_onb      = 1'b1;
                                r_req      = src;
                                owner_next = src;
                            end
                            msidc_pkg::K_PUTS:
                            begin
                                r_type = msidc_pkg::MT_PUTACK;
                            end
                            msidc_pkg::K_PUTM:
                            begin
                                if (src == owner_reg)
                                begin
                                    ownv_next  = 1'b0;
                                    owner_next = 3'd0;
                                    line_next  = msidc_pkg::ST_I;
                                end
                            end
                            default:
                            begin
                                r_valid  = 1'b0;
                                r_status = msidc_pkg::STAT_UNHANDLED;
                            end
                        endcase
                    end
                end
                msidc_pkg::ST_SD:
                begin
                    case (kind)
                        msidc_pkg::K_GETS, msidc_pkg::K_GETM:
                        begin
                            r_valid  = 1'b0;
                            r_status = msidc_pkg::STAT_STALL;
                        end
                        msidc_pkg::K_PUTS, msidc_pkg::K_PUTM:
                        begin
                            sharer_next = shm & ~sbit;
                        end
                        msidc_pkg::K_DATA:
                        begin
                            r_valid   = 1'b0;
                            line_next = msidc_pkg::ST_S;
                        end
                        default:
                        begin
                            r_valid  = 1'b0;
                            r_status = msidc_pkg::STAT_UNHANDLED;
                        end
                    endcase
                end
                default:
                begin
                    r_valid = 1'b0;
                end
            endcase
        end
        if (!r_valid)
        begin
            r_type = 3'd0;
            r_dest = 3'd0;
            r_onb  = 1'b0;
            r_req  = 3'd0;
            r_ack  = 3'd0;
            r_ord  = 1'b0;
        end
    end

    // The lowest pending sharer is invalidated first.
    always_comb
    begin
        inv_idx = 3'd0;
        for (int i = 7; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                inv_idx = 3'(i);
            end
        end
    end

    assign inv_bit   = 8'b1 << inv_idx;
    assign pend_rest = pend_reg & ~inv_bit;

    assign stat.out_free  = !out_valid_reg || out_ready;
    assign stat.start_inv = inv_mask != 8'd0;
    assign stat.inv_final = pend_rest == 8'd0;

    always_comb
    begin
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (cmd.accept)
        begin
            pend_next      = inv_mask;
            out_valid_next = 1'b1;
        end
        else if (cmd.emit_inv)
        begin
            pend_next      = pend_rest;
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg      <= msidc_pkg::ST_I;
            owner_reg     <= 3'd0;
            ownv_reg      <= 1'b0;
            sharer_reg    <= 8'd0;
            pend_reg      <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cmd.accept)
            begin
                line_reg   <= line_next;
                owner_reg  <= owner_next;
                ownv_reg   <= ownv_next;
                sharer_reg <= sharer_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg      <= src;
            out_data_reg <= {2'b00, r_ord, r_ack, r_req, r_onb, r_dest, r_type};
            out_user_reg <= {r_status, r_valid};
            out_last_reg <= inv_mask == 8'd0;
        end
        else if (cmd.emit_inv)
        begin
            out_data_reg <= {2'b00, 1'b1, 3'd0, req_reg, 1'b1, inv_idx, msidc_pkg::MT_INV};
            out_user_reg <= {msidc_pkg::STAT_OK, 1'b1};
            out_last_reg <= pend_rest == 8'd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = out_user_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ----- rtl/msi_directory_controller_core.sv -----
// The first result item is registered when its input item is accepted.
// Throughput: one input item per cycle when each gives a single result item, while the
// output is not stalled. A GetM in S with n other sharers holds off input until its n Invs
// are sent, one Inv per cycle while unstalled, paced by the single output register.
// Reset (rst_n low, asynchronous) sets the line to I with no owner and no sharers.
`timescale 1ns / 1ps
`default_nettype none

`include "msi_directory_controller_core_assert.svh"

module msi_directory_controller_core
#(
    parameter int CACHES = msidc_pkg::CACHES_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // Bits: source_cache [2:0], zero [7:3].
    input  wire logic [7:0]  s_axis_tdata,
    // Bits: kind [3:0].
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // Bits: message_type [2:0], dest_cache [5:3], on_behalf [6], requester [9:7],
    // ack_count [12:10], ordered [13], zero [15:14].
    output logic [15:0]      m_axis_tdata,
    // Bits: message_valid [0], status [2:1].
    output logic [2:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    msidc_pkg::ctrl_cmd_t cmd;
    msidc_pkg::dp_stat_t  stat;

    msidc_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .in_ready (s_axis_tready),
        .cmd      (cmd)
    );

    msidc_dp #(.CACHES(CACHES)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (s_axis_tdata),
        .in_user   (s_axis_tuser),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_axis_tvalid),
        .out_data  (m_axis_tdata),
        .out_user  (m_axis_tuser),
        .out_last  (m_axis_tlast)
    );

    `MSIDC_ASSERT_NOW(a_no_accept_while_inv, clk, rst_n, cmd.emit_inv, !s_axis_tready)
    `MSIDC_ASSERT_NOW(a_status_only_last, clk, rst_n, m_axis_tvalid && !m_axis_tuser[0], m_axis_tlast)
    `MSIDC_ASSERT_NOW(a_error_last, clk, rst_n, m_axis_tvalid && (m_axis_tuser[2:1] != msidc_pkg::STAT_OK), m_axis_tlast)
    `MSIDC_ASSERT_NEXT(a_inv_blocks_input, clk, rst_n, cmd.accept && stat.start_inv, !s_axis_tready && !m_axis_tlast)

endmodule

`default_nettype wire
